@@ hw/rtl/ffba_pkg.sv @@
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned AddrW = 21;
  localparam int unsigned HdrW  = 7;
  // wide enough for heap_top + header_bytes + req_size
  localparam int unsigned SumW  = 23;

  // request kinds carried on the input tuser
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // configuration register indexes (byte address 4 * index)
  localparam logic RegHeapLimit   = 1'b0;
  localparam logic RegHeaderBytes = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FREED     = 3'd3,
    ST_BAD_ADDR  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_e;

  typedef enum logic {
    CMP_GE,
    CMP_EQ
  } cmp_op_e;

  // one row of the block table
  typedef struct packed {
    logic [AddrW-1:0] data_addr;
    logic [AddrW-1:0] size;
    logic             is_free;
  } entry_t;

  // operands for the shared comparator
  typedef struct packed {
    cmp_op_e         op;
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
  } cmp_req_t;

endpackage

@@ hw/rtl/ffba_table.sv @@
// block table memory: one write port, one registered read port
module ffba_table #(
  parameter int unsigned MAX_BLOCKS = 64,
  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  ffba_pkg::entry_t  wdata_i,
  input  logic [IdxW-1:0]   raddr_i,
  output ffba_pkg::entry_t  rdata_o
);
  import ffba_pkg::*;

  entry_t mem_q [MAX_BLOCKS];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ffba_match.sv @@
// shared comparator used by the table scan and the append limit check
module ffba_match (
  input  ffba_pkg::cmp_req_t req_i,
  output logic               hit_o
);
  import ffba_pkg::*;

  always_comb begin
    case (req_i.op)
      CMP_GE:  hit_o = (req_i.a >= req_i.b);
      CMP_EQ:  hit_o = (req_i.a == req_i.b);
      default: hit_o = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/ffba_ctrl.sv @@
// sequencer: walks the block table, appends blocks and holds the result item
module ffba_ctrl #(
  parameter int unsigned MAX_BLOCKS = 64,
  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ffba_pkg::AddrW-1:0]    req_size_i,
  input  logic [ffba_pkg::AddrW-1:0]    free_addr_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffba_pkg::status_e             status_o,
  output logic [ffba_pkg::AddrW-1:0]    result_addr_o,
  // configuration
  input  logic [ffba_pkg::AddrW-1:0]    heap_limit_i,
  input  logic [ffba_pkg::HdrW-1:0]     header_bytes_i,
  // block table
  output logic                          tbl_we_o,
  output logic [IdxW-1:0]               tbl_waddr_o,
  output ffba_pkg::entry_t              tbl_wdata_o,
  output logic [IdxW-1:0]               tbl_raddr_o,
  input  ffba_pkg::entry_t              tbl_rdata_i,
  // shared comparator
  output ffba_pkg::cmp_req_t            cmp_req_o,
  input  logic                          cmp_hit_i
);
  import ffba_pkg::*;

  state_e             state_q, state_d;
  logic               req_type_q, req_type_d;
  logic [AddrW-1:0]   req_size_q, req_size_d;
  logic [AddrW-1:0]   free_addr_q, free_addr_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AddrW:0]     base_q, base_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [AddrW-1:0]   top_q, top_d;
  status_e            res_status_q, res_status_d;
  logic [AddrW-1:0]   res_addr_q, res_addr_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [AddrW-1:0]   out_addr_q, out_addr_d;

  logic               accept;
  logic               last_entry;
  logic               table_full;
  logic [SumW-1:0]    need;
  logic [CntW-1:0]    idx_next;

  assign accept     = in_valid_i && in_ready_o;
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign last_entry = (idx_next == count_q);
  assign table_full = (count_q >= CntW'(MAX_BLOCKS));
  assign need       = SumW'(base_q) + SumW'(req_size_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk_i) begin
    req_type_q   <= req_type_d;
    req_size_q   <= req_size_d;
    free_addr_q  <= free_addr_d;
    idx_q        <= idx_d;
    base_q       <= base_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    req_type_d   = req_type_q;
    req_size_d   = req_size_q;
    free_addr_d  = free_addr_q;
    idx_d        = idx_q;
    base_d       = base_q;
    count_d      = count_q;
    top_d        = top_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;

    in_ready_o   = 1'b0;
    tbl_we_o     = 1'b0;
    tbl_waddr_o  = idx_q;
    tbl_wdata_o  = tbl_rdata_i;
    tbl_raddr_o  = '0;
    cmp_req_o.op = CMP_EQ;
    cmp_req_o.a  = SumW'(tbl_rdata_i.data_addr);
    cmp_req_o.b  = SumW'(free_addr_q);

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          req_type_d  = req_type_i;
          req_size_d  = req_size_i;
          free_addr_d = free_addr_i;
          idx_d       = '0;
          base_d      = (AddrW+1)'(top_q) + (AddrW+1)'(header_bytes_i);
          res_addr_d  = '0;
          if (req_type_i == ReqAlloc && req_size_i == '0) begin
            res_status_d = ST_ZERO_SIZE;
            state_d      = S_RESP;
          end else if (req_type_i == ReqFree && free_addr_i == '0) begin
            res_status_d = ST_BAD_ADDR;
            state_d      = S_RESP;
          end else if (count_q == '0) begin
            if (req_type_i == ReqAlloc) begin
              state_d = S_APPEND;
            end else begin
              res_status_d = ST_BAD_ADDR;
              state_d      = S_RESP;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // one table entry per cycle; read of the next entry runs ahead
      S_SCAN: begin
        tbl_raddr_o = idx_next[IdxW-1:0];
        if (req_type_q == ReqAlloc) begin
          cmp_req_o.op = CMP_GE;
          cmp_req_o.a  = SumW'(tbl_rdata_i.size);
          cmp_req_o.b  = SumW'(req_size_q);
        end
        if (req_type_q == ReqAlloc && tbl_rdata_i.is_free && cmp_hit_i) begin
          tbl_we_o            = 1'b1;
          tbl_wdata_o.is_free = 1'b0;
          res_status_d        = ST_ALLOCATED;
          res_addr_d          = tbl_rdata_i.data_addr;
          state_d             = S_RESP;
        end else if (req_type_q == ReqFree && cmp_hit_i) begin
          tbl_we_o            = 1'b1;
          tbl_wdata_o.is_free = 1'b1;
          res_status_d        = ST_FREED;
          state_d             = S_RESP;
        end else if (last_entry) begin
          if (req_type_q == ReqAlloc) begin
            state_d = S_APPEND;
          end else begin
            res_status_d = ST_BAD_ADDR;
            state_d      = S_RESP;
          end
        end else begin
          idx_d = idx_next[IdxW-1:0];
        end
      end

      // new block at the heap top
      S_APPEND: begin
        cmp_req_o.op = CMP_GE;
        cmp_req_o.a  = SumW'(heap_limit_i);
        cmp_req_o.b  = need;
        tbl_waddr_o  = count_q[IdxW-1:0];
        tbl_wdata_o.data_addr = base_q[AddrW-1:0];
        tbl_wdata_o.size      = req_size_q;
        tbl_wdata_o.is_free   = 1'b0;
        if (table_full || !cmp_hit_i) begin
          res_status_d = ST_NO_SPACE;
        end else begin
          tbl_we_o     = 1'b1;
          res_status_d = ST_ALLOCATED;
          res_addr_d   = base_q[AddrW-1:0];
          count_d      = count_q + CntW'(1);
          top_d        = need[AddrW-1:0];
        end
        state_d = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_addr_o = out_addr_q;

endmodule

@@ hw/rtl/first_fit_block_allocator.sv @@
// first-fit heap block allocator: top level with configuration registers
//
// Request items enter on the s_axis channel: tuser is the kind (0 allocate,
// 1 free), tdata carries req_size and free_addr. Each request gives exactly
// one result item on m_axis: tuser is the status, tdata the data address.
// heap_limit (address 0) and header_bytes (address 4) are written through
// the APB port; the user must write them only while the allocator is idle,
// which the block does not enforce. A request is taken only in the idle
// state. Zero-size and null requests go straight to the result; otherwise
// a non-empty block table (at most MAX_BLOCKS blocks) is walked one entry
// per cycle through the single read port of the table memory, and the heap
// top is checked when no free block fits an allocation.
// The result sits in an output register; a new request is accepted while it
// waits for m_axis_tready, and a stalled receiver only holds the sequencer
// once the next result is ready.
// Reset empties the heap (no blocks, heap top 0) and restores heap_limit to
// 1048576 and header_bytes to 24. The table memory needs no clearing pass.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64,
  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [20:0] req_size, [41:21] free_addr, rest zero
  input  logic        s_axis_tuser,   // [0] req_type
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] result_addr, rest zero
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffba_pkg::*;

  logic [AddrW-1:0] heap_limit_q;
  logic [HdrW-1:0]  header_bytes_q;
  logic             cfg_write;

  logic             tbl_we;
  logic [IdxW-1:0]  tbl_waddr;
  entry_t           tbl_wdata;
  logic [IdxW-1:0]  tbl_raddr;
  entry_t           tbl_rdata;
  cmp_req_t         cmp_req;
  logic             cmp_hit;
  status_e          status;
  logic [AddrW-1:0] result_addr;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q   <= AddrW'(1048576);
      header_bytes_q <= HdrW'(24);
    end else if (cfg_write) begin
      case (paddr[2])
        RegHeapLimit:   heap_limit_q   <= pwdata[AddrW-1:0];
        RegHeaderBytes: header_bytes_q <= pwdata[HdrW-1:0];
        default:        ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      RegHeapLimit:   prdata = 32'(heap_limit_q);
      RegHeaderBytes: prdata = 32'(header_bytes_q);
      default:        prdata = '0;
    endcase
  end

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .req_size_i     (s_axis_tdata[20:0]),
    .free_addr_i    (s_axis_tdata[41:21]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .result_addr_o  (result_addr),
    .heap_limit_i   (heap_limit_q),
    .header_bytes_i (header_bytes_q),
    .tbl_we_o       (tbl_we),
    .tbl_waddr_o    (tbl_waddr),
    .tbl_wdata_o    (tbl_wdata),
    .tbl_raddr_o    (tbl_raddr),
    .tbl_rdata_i    (tbl_rdata),
    .cmp_req_o      (cmp_req),
    .cmp_hit_i      (cmp_hit)
  );

  ffba_table #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  ffba_match u_match (
    .req_i (cmp_req),
    .hit_o (cmp_hit)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {3'b000, result_addr};

endmodule

@@ hw/rtl/ffba_checker.sv @@
// port-level checks for the allocator, bound to the top level
module ffba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        pready
);
  import ffba_pkg::*;

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= 3'(ST_BAD_ADDR)))
    else $error("undefined status code");

  // only a successful allocation carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != 3'(ST_ALLOCATED)) |-> (m_axis_tdata == '0))
    else $error("address on a non-allocation result");

  // one request at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
